// ----- rtl/sflc_pkg.sv -----
// Shared types, constants and codes for the safety-loop flash counter.
`timescale 1ns / 1ps
package sflc_pkg;

	// Number of monitored lines, and widths that follow from it
	localparam int LINES  = 4;
	localparam int LINE_W = (LINES > 4) ? 3 : 2;
	localparam int ADDR_W = (LINES > 1) ? $clog2(LINES) : 1;

	// Fixed field widths
	localparam int LEVEL_W = 4;
	localparam int CNT_W   = 8;
	localparam int NIB_W   = 4;
	localparam int CFG_W   = 8;
	localparam int CFG_IDX_W = 1;

	// Line counter limits
	localparam logic [LINE_W:0]   LINE_END  = (LINE_W + 1)'(LINES);
	localparam logic [LINE_W:0]   LEVEL_END = (LINE_W + 1)'(LEVEL_W);
	localparam logic [LINE_W-1:0] TICK_LAST = LINE_W'(LINES - 1);
	localparam logic [LINE_W-1:0] READ_LAST = LINE_W'(1);

	// Saturation points
	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;
	localparam logic [NIB_W-1:0] NIB_MAX = 4'd15;

	// Register reset values
	localparam logic [CFG_W-1:0] WINDOW_RESET = 8'd100;
	localparam logic [CFG_W-1:0] STABLE_RESET = 8'd20;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_LIMIT = 1'd1;

	// Request modes
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// Per-line phase machine
	typedef enum logic [6:0] {
		PH_PON  = 7'b0000001,
		PH_HIGH = 7'b0000010,
		PH_H_TL = 7'b0000100,
		PH_H_TH = 7'b0001000,
		PH_LOW  = 7'b0010000,
		PH_L_TH = 7'b0100000,
		PH_L_TL = 7'b1000000
	} phase_t;

	// Request payload
	typedef struct packed {
		logic               mode;
		logic [LEVEL_W-1:0] line_levels;
		logic               pair_select;
		logic               clear_previous;
	} req_t;

	// Result payload
	typedef struct packed {
		logic [2*NIB_W-1:0] flash_result;
		logic               pair_echo;
	} res_t;

	// One memory entry: the whole state of one line
	typedef struct packed {
		phase_t             phase;
		logic [CNT_W-1:0]   stable_run;
		logic [CNT_W-1:0]   window_run;
		logic [CNT_W-1:0]   pending_flashes;
		logic [CNT_W-1:0]   reported_flashes;
		logic [CNT_W-1:0]   previously_sent;
	} line_state_t;

	localparam line_state_t LINE_RESET = '{PH_PON, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

	// Control for one line operation
	typedef struct packed {
		logic read;
		logic level;
		logic clear;
	} line_op_t;

endpackage

// ----- rtl/sflc_update.sv -----
// Next-state logic for one line: a sample tick or a count read.
`timescale 1ns / 1ps
module sflc_update (
	input  sflc_pkg::line_state_t           cur,
	input  sflc_pkg::line_op_t              op,
	input  logic [sflc_pkg::CFG_W-1:0]      window_limit,
	input  logic [sflc_pkg::CFG_W-1:0]      stable_limit,
	output sflc_pkg::line_state_t           nxt,
	output logic [sflc_pkg::NIB_W-1:0]      nibble
);

	// A sample changes phase at most three times before it is counted
	localparam int STEPS = 4;

	function automatic logic [sflc_pkg::CNT_W-1:0] sat_add(
		input logic [sflc_pkg::CNT_W-1:0] a,
		input logic [sflc_pkg::CNT_W-1:0] b
	);
		logic [sflc_pkg::CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[sflc_pkg::CNT_W] ? sflc_pkg::CNT_MAX : s[sflc_pkg::CNT_W-1:0];
	endfunction

	function automatic sflc_pkg::line_state_t report(input sflc_pkg::line_state_t s);
		sflc_pkg::line_state_t r;
		r = s;
		r.reported_flashes = sat_add(s.reported_flashes, s.pending_flashes);
		r.pending_flashes  = '0;
		return r;
	endfunction

	function automatic logic is_running(input sflc_pkg::phase_t p);
		logic v;
		unique case (p)
			sflc_pkg::PH_HIGH, sflc_pkg::PH_H_TL, sflc_pkg::PH_H_TH,
			sflc_pkg::PH_LOW, sflc_pkg::PH_L_TH, sflc_pkg::PH_L_TL: v = 1'b1;
			default: v = 1'b0;
		endcase
		return v;
	endfunction

	function automatic logic expect_high(input sflc_pkg::phase_t p);
		return (p == sflc_pkg::PH_HIGH) || (p == sflc_pkg::PH_H_TH) ||
			(p == sflc_pkg::PH_L_TH);
	endfunction

	// One run piece of n samples (0 or 1); closed when the level changed
	function automatic sflc_pkg::line_state_t run_phase(
		input sflc_pkg::line_state_t      s,
		input logic                       n,
		input logic                       closed,
		input logic [sflc_pkg::CFG_W-1:0] wl,
		input logic [sflc_pkg::CFG_W-1:0] sl
	);
		sflc_pkg::line_state_t       r;
		logic [sflc_pkg::CNT_W-1:0]  inc;
		logic [sflc_pkg::CNT_W:0]    wsum;
		logic [sflc_pkg::CNT_W:0]    gap_sum;
		logic [sflc_pkg::CNT_W+1:0]  sl3;
		r       = s;
		inc     = {{(sflc_pkg::CNT_W-1){1'b0}}, n};
		wsum    = {1'b0, s.window_run} + {1'b0, inc};
		gap_sum = {1'b0, s.stable_run} + {1'b0, wl - s.window_run};
		sl3     = {2'b00, sl} + {1'b0, sl, 1'b0};
		unique case (s.phase)
			sflc_pkg::PH_HIGH: begin
				if (closed) begin
					r.pending_flashes = 8'd1;
					r.stable_run      = '0;
					r.window_run      = '0;
					r.phase           = sflc_pkg::PH_H_TL;
				end
			end
			sflc_pkg::PH_H_TL: begin
				// report early when the window ends before the level could settle
				if ((s.window_run < wl) && (wsum >= {1'b0, wl}) && (gap_sum < {1'b0, sl}))
					r = report(r);
				r.stable_run = sat_add(r.stable_run, inc);
				r.window_run = sat_add(r.window_run, inc);
				if (r.stable_run >= sl) begin
					r.phase = sflc_pkg::PH_LOW;
				end else begin
					if (r.window_run >= wl)
						r = report(r);
					if (closed) begin
						r.phase      = sflc_pkg::PH_H_TH;
						r.stable_run = '0;
					end
				end
			end
			sflc_pkg::PH_H_TH: begin
				r.stable_run = sat_add(r.stable_run, inc);
				r.window_run = sat_add(r.window_run, inc);
				if (r.window_run >= wl)
					r = report(r);
				if (r.stable_run >= sl) begin
					r.reported_flashes = sat_add(r.reported_flashes, r.pending_flashes);
					r.phase            = sflc_pkg::PH_HIGH;
				end else if (closed) begin
					r.pending_flashes = sat_add(r.pending_flashes, 8'd1);
					r.phase           = sflc_pkg::PH_H_TL;
					r.stable_run      = '0;
				end
			end
			sflc_pkg::PH_LOW: begin
				if (closed) begin
					r.pending_flashes = '0;
					r.stable_run      = '0;
					r.window_run      = '0;
					r.phase           = sflc_pkg::PH_L_TH;
				end
			end
			sflc_pkg::PH_L_TH: begin
				r.stable_run = sat_add(r.stable_run, inc);
				r.window_run = sat_add(r.window_run, inc);
				if ({2'b00, r.stable_run} > sl3) begin
					r.phase = sflc_pkg::PH_HIGH;
				end else if (closed) begin
					r.phase      = sflc_pkg::PH_L_TL;
					r.stable_run = '0;
				end
			end
			sflc_pkg::PH_L_TL: begin
				r.stable_run = sat_add(r.stable_run, inc);
				r.window_run = sat_add(r.window_run, inc);
				if (r.stable_run > sl) begin
					r.phase = sflc_pkg::PH_LOW;
				end else if (closed) begin
					r.phase      = sflc_pkg::PH_L_TH;
					r.stable_run = '0;
				end
			end
			default: r.phase = sflc_pkg::PH_PON;
		endcase
		return r;
	endfunction

	sflc_pkg::line_state_t      tick_st;
	sflc_pkg::line_state_t      read_st;
	logic [sflc_pkg::NIB_W-1:0] read_nib;

	// Sample path: close runs until the level fits the phase, then count it
	always_comb begin
		logic done;
		tick_st = cur;
		done    = 1'b0;
		for (int k = 0; k < STEPS; k++) begin
			if (!done) begin
				if (!is_running(tick_st.phase)) begin
					tick_st.phase = op.level ? sflc_pkg::PH_HIGH : sflc_pkg::PH_LOW;
					done          = 1'b1;
				end else if (op.level == expect_high(tick_st.phase)) begin
					tick_st = run_phase(tick_st, 1'b1, 1'b0, window_limit, stable_limit);
					done    = 1'b1;
				end else begin
					tick_st = run_phase(tick_st, 1'b0, 1'b1, window_limit, stable_limit);
				end
			end
		end
	end

	// Read path: add previously sent, saturate to a nibble, hand over the counts
	always_comb begin
		logic [sflc_pkg::CNT_W-1:0] prev;
		logic [sflc_pkg::CNT_W:0]   total;
		prev  = op.clear ? '0 : cur.previously_sent;
		total = {1'b0, cur.reported_flashes} + {1'b0, prev};
		read_nib = (total > {5'd0, sflc_pkg::NIB_MAX}) ? sflc_pkg::NIB_MAX
			: total[sflc_pkg::NIB_W-1:0];
		read_st                  = cur;
		read_st.previously_sent  = cur.reported_flashes;
		read_st.reported_flashes = '0;
	end

	assign nxt    = op.read ? read_st : tick_st;
	assign nibble = op.read ? read_nib : '0;

endmodule

// ----- rtl/safety_loop_flash_counter.sv -----
// Top level of the safety-loop flash counter: sequencer, line state memory, result register.
`timescale 1ns / 1ps
// A tick request updates every line, one line per cycle through the line state memory
// (one read port, one write port, registered read), so it holds the request port until
// its last line issues, and the next request is taken in the cycle its last line issues.
// A read request steps through the two lines of the pair, one line per issue, and its result
// is registered as its second line leaves execute. A read waits before its first line while an
// earlier result is still unclaimed or still in flight, and holds the request port while it
// waits; a tick is never held by a pending result. A line's update is written back in the cycle
// after its read, with the written entry forwarded to a read of the same line in that
// cycle. Reset clears the per-entry valid bits at once, so there is no clearing pass.
module safety_loop_flash_counter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  sflc_pkg::req_t                    req_data,
	output logic                              res_valid,
	input  logic                              res_stall,
	output sflc_pkg::res_t                    res_data,
	input  logic                              cfg_we,
	input  logic [sflc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sflc_pkg::CFG_W-1:0]        cfg_data
);

	// Configuration registers
	logic [sflc_pkg::CFG_W-1:0] window_q;
	logic [sflc_pkg::CFG_W-1:0] stable_q;

	// Held request and line sequencer
	sflc_pkg::req_t              cur_q;
	logic                        cur_vld_q;
	logic [sflc_pkg::LINE_W-1:0] idx_q;

	// Issue stage
	logic [sflc_pkg::LINE_W-1:0] op_line;
	logic [sflc_pkg::LINE_W-1:0] op_base;
	logic                        op_last;
	logic                        op_in_range;
	logic                        op_level;
	logic                        read_block;
	logic                        issue;
	logic [sflc_pkg::ADDR_W-1:0] rd_addr;
	sflc_pkg::line_op_t          op;

	// Line state memory with valid bits
	sflc_pkg::line_state_t       mem [sflc_pkg::LINES];
	logic [sflc_pkg::LINES-1:0]  ent_vld_q;

	// Execute stage
	logic                        vld_s1;
	logic [sflc_pkg::LINE_W-1:0] line_s1;
	sflc_pkg::line_op_t          op_s1;
	logic                        last_s1;
	logic                        in_range_s1;
	logic                        pair_s1;
	sflc_pkg::line_state_t       rd_raw_s1;
	logic                        ent_vld_s1;
	logic                        fwd_s1;
	sflc_pkg::line_state_t       fwd_data_s1;
	sflc_pkg::line_state_t       cur_state;
	sflc_pkg::line_state_t       nxt_state;
	logic [sflc_pkg::NIB_W-1:0]  upd_nib;
	logic [sflc_pkg::NIB_W-1:0]  nib;
	logic                        wr_en;
	logic [sflc_pkg::ADDR_W-1:0] wr_addr;

	// Result side
	logic [sflc_pkg::NIB_W-1:0]  coil_q;
	logic                        res_vld_q;
	sflc_pkg::res_t              res_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= sflc_pkg::WINDOW_RESET;
			stable_q <= sflc_pkg::STABLE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sflc_pkg::CFG_WINDOW_LIMIT: window_q <= cfg_data;
				sflc_pkg::CFG_STABLE_LIMIT: stable_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pick the line for this cycle and decide whether it may issue
	always_comb begin
		op_base     = (cur_q.mode == sflc_pkg::MODE_READ)
			? sflc_pkg::LINE_W'({cur_q.pair_select, 1'b0}) : '0;
		op_line     = op_base + idx_q;
		op_last     = (cur_q.mode == sflc_pkg::MODE_READ) ? (idx_q == sflc_pkg::READ_LAST)
			: (idx_q == sflc_pkg::TICK_LAST);
		op_in_range = {1'b0, op_line} < sflc_pkg::LINE_END;
		op_level    = ({1'b0, op_line} < sflc_pkg::LEVEL_END) ? cur_q.line_levels[op_line[1:0]]
			: 1'b0;
		read_block  = (cur_q.mode == sflc_pkg::MODE_READ) && (idx_q == '0) &&
			(res_vld_q || (vld_s1 && op_s1.read));
		issue       = cur_vld_q && !read_block;
		rd_addr     = op_line[sflc_pkg::ADDR_W-1:0];
		op.read     = (cur_q.mode == sflc_pkg::MODE_READ);
		op.level    = op_level;
		op.clear    = cur_q.clear_previous;
	end

	assign req_stall = cur_vld_q && !(issue && op_last);

	// Hold the request and advance through its lines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
		end else if (req_valid && !req_stall) begin
			cur_vld_q <= 1'b1;
			idx_q     <= '0;
		end else if (issue && op_last) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
		end else if (issue) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			cur_q <= req_data;
	end

	// Memory: write back the updated line, read the issuing line
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= nxt_state;
		if (issue)
			rd_raw_s1 <= mem[rd_addr];
	end

	// Mark written entries valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ent_vld_q <= '0;
		else if (wr_en)
			ent_vld_q[wr_addr] <= 1'b1;
	end

	// Advance the issue stage into execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			op_s1  <= '0;
		end else begin
			vld_s1 <= issue;
			if (issue)
				op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			line_s1     <= op_line;
			last_s1     <= op_last;
			in_range_s1 <= op_in_range;
			pair_s1     <= cur_q.pair_select;
			ent_vld_s1  <= ent_vld_q[rd_addr];
			fwd_s1      <= wr_en && (wr_addr == rd_addr);
			fwd_data_s1 <= nxt_state;
		end
	end

	// Pick forwarded, stored or reset state for the line in execute
	always_comb begin
		if (fwd_s1)
			cur_state = fwd_data_s1;
		else if (ent_vld_s1)
			cur_state = rd_raw_s1;
		else
			cur_state = sflc_pkg::LINE_RESET;
	end

	sflc_update u_update (
		.cur          (cur_state),
		.op           (op_s1),
		.window_limit (window_q),
		.stable_limit (stable_q),
		.nxt          (nxt_state),
		.nibble       (upd_nib)
	);

	assign wr_en   = vld_s1 && in_range_s1;
	assign wr_addr = line_s1[sflc_pkg::ADDR_W-1:0];
	assign nib     = in_range_s1 ? upd_nib : '0;

	// Hold the coil nibble until the contact line finishes
	always_ff @(posedge clk) begin
		if (vld_s1 && op_s1.read && !last_s1)
			coil_q <= nib;
	end

	// Load the result register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_q <= 1'b0;
		else if (vld_s1 && op_s1.read && last_s1)
			res_vld_q <= 1'b1;
		else if (!res_stall)
			res_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && op_s1.read && last_s1) begin
			res_q.flash_result <= {coil_q, nib};
			res_q.pair_echo    <= pair_s1;
		end
	end

	assign res_valid = res_vld_q;
	assign res_data  = res_q;

endmodule

// ----- rtl/sflc_check.sv -----
// Port-level checks for the safety-loop flash counter, bound to the top level.
`timescale 1ns / 1ps
module sflc_check (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input sflc_pkg::req_t req_data,
	input logic           res_valid,
	input logic           res_stall,
	input sflc_pkg::res_t res_data
);

	// A stalled result stays and holds its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result dropped or changed while stalled");

	// With no request held, the port stays open
	a_idle_open: assert property (@(posedge clk) disable iff (!arst_n)
		!req_stall && !req_valid |=> !req_stall)
		else $error("request port stalled with nothing held");

	// A tick holds the port while its lines are walked
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req_data.mode == sflc_pkg::MODE_TICK) |=> req_stall)
		else $error("tick released the port too early");

	// A tick frees the port once its last line has issued
	a_tick_done: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req_data.mode == sflc_pkg::MODE_TICK)
		|-> ##(sflc_pkg::LINES) !req_stall)
		else $error("tick held the port too long");

endmodule

bind safety_loop_flash_counter sflc_check u_sflc_check (.*);

// ----- tb/flash_count_checker.sv -----
// Checker for the safety-loop flash counter: line state prediction and result comparison.
`timescale 1ns / 1ps
module flash_count_checker
	import sflc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  req_t                 req_data,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  res_t                 res_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatch_count,
	output int                   reads_waiting,
	output int                   reads_checked
);

	// Shadow copy of the limit registers
	logic [CFG_W-1:0] window_limit;
	logic [CFG_W-1:0] stable_limit;

	// Shadow copy of the per-line state
	phase_t           phase      [LINES];
	logic [CNT_W-1:0] stable_run [LINES];
	logic [CNT_W-1:0] window_run [LINES];
	logic [CNT_W-1:0] pending    [LINES];
	logic [CNT_W-1:0] reported   [LINES];
	logic [CNT_W-1:0] sent       [LINES];

	// Read results predicted but not yet seen, oldest first
	res_t expected_counts [$];

	function automatic logic [CNT_W-1:0] sat_add8(int unsigned a, int unsigned b);
		int unsigned sum;
		sum = a + b;
		return (sum > 255) ? CNT_MAX : CNT_W'(sum);
	endfunction

	// Move pending flashes into the reported count
	function automatic void flush_pending(int i);
		reported[i] = sat_add8(reported[i], pending[i]);
		pending[i] = '0;
	endfunction

	function automatic void count_sample(int i, int unsigned n);
		stable_run[i] = sat_add8(stable_run[i], n);
		window_run[i] = sat_add8(window_run[i], n);
	endfunction

	// Advance one line by a run piece of n samples; closed marks a level change
	function automatic void step_phase(int i, int unsigned n, bit closed);
		int unsigned wl;
		int unsigned sl;
		wl = window_limit;
		sl = stable_limit;
		case (phase[i])
			PH_HIGH: begin
				if (closed) begin
					pending[i]    = 8'd1;
					stable_run[i] = '0;
					window_run[i] = '0;
					phase[i]      = PH_H_TL;
				end
			end
			PH_H_TL: begin
				// report early when the window ends before the level can settle
				if (window_run[i] < wl && window_run[i] + n >= wl &&
				    stable_run[i] + (wl - window_run[i]) < sl)
					flush_pending(i);
				count_sample(i, n);
				if (stable_run[i] >= sl) begin
					phase[i] = PH_LOW;
				end else begin
					if (window_run[i] >= wl)
						flush_pending(i);
					if (closed) begin
						phase[i]      = PH_H_TH;
						stable_run[i] = '0;
					end
				end
			end
			PH_H_TH: begin
				count_sample(i, n);
				if (window_run[i] >= wl)
					flush_pending(i);
				if (stable_run[i] >= sl) begin
					// pending stays as it is here
					reported[i] = sat_add8(reported[i], pending[i]);
					phase[i]    = PH_HIGH;
				end else if (closed) begin
					pending[i]    = sat_add8(pending[i], 1);
					phase[i]      = PH_H_TL;
					stable_run[i] = '0;
				end
			end
			PH_LOW: begin
				if (closed) begin
					pending[i]    = '0;
					stable_run[i] = '0;
					window_run[i] = '0;
					phase[i]      = PH_L_TH;
				end
			end
			PH_L_TH: begin
				count_sample(i, n);
				if (stable_run[i] > 3 * sl) begin
					phase[i] = PH_HIGH;
				end else if (closed) begin
					phase[i]      = PH_L_TL;
					stable_run[i] = '0;
				end
			end
			PH_L_TL: begin
				count_sample(i, n);
				if (stable_run[i] > sl) begin
					phase[i] = PH_LOW;
				end else if (closed) begin
					phase[i]      = PH_L_TH;
					stable_run[i] = '0;
				end
			end
			default: begin
				phase[i] = PH_PON;
			end
		endcase
	endfunction

	// Feed one sample; a mismatching level closes the run and is tried again
	function automatic void take_sample(int i, logic level);
		logic high_wanted;
		int   k;
		for (k = 0; k < 8; k++) begin
			if (phase[i] == PH_PON) begin
				phase[i] = level ? PH_HIGH : PH_LOW;
				return;
			end
			high_wanted = phase[i] inside {PH_HIGH, PH_H_TH, PH_L_TH};
			if (level == high_wanted) begin
				step_phase(i, 1, 1'b0);
				return;
			end
			step_phase(i, 0, 1'b1);
		end
	endfunction

	// Return the nibble for one line and roll its counts into previously sent
	function automatic logic [NIB_W-1:0] read_count(int i, bit clr);
		int unsigned total;
		if (i >= LINES)
			return '0;
		if (clr)
			sent[i] = '0;
		total       = reported[i] + sent[i];
		sent[i]     = reported[i];
		reported[i] = '0;
		return (total > 15) ? NIB_MAX : NIB_W'(total);
	endfunction

	// Compare results, track register writes, predict on each request
	always @(posedge clk or negedge arst_n) begin
		res_t             want;
		logic [NIB_W-1:0] coil;
		logic [NIB_W-1:0] contact;
		if (!arst_n) begin
			window_limit = WINDOW_RESET;
			stable_limit = STABLE_RESET;
			for (int i = 0; i < LINES; i++) begin
				phase[i]      = PH_PON;
				stable_run[i] = '0;
				window_run[i] = '0;
				pending[i]    = '0;
				reported[i]   = '0;
				sent[i]       = '0;
			end
			expected_counts.delete();
			mismatch_count = 0;
			reads_waiting  = 0;
			reads_checked  = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_counts.size() == 0) begin
					$error("unexpected result: flash_result 0x%02h pair_echo %0d",
						res_data.flash_result, res_data.pair_echo);
					mismatch_count++;
				end else begin
					want = expected_counts.pop_front();
					if (res_data.flash_result !== want.flash_result) begin
						$error("flash_result: expected 0x%02h, actual 0x%02h",
							want.flash_result, res_data.flash_result);
						mismatch_count++;
					end
					if (res_data.pair_echo !== want.pair_echo) begin
						$error("pair_echo: expected %0d, actual %0d",
							want.pair_echo, res_data.pair_echo);
						mismatch_count++;
					end
					reads_checked++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW_LIMIT: window_limit = cfg_data;
					CFG_STABLE_LIMIT: stable_limit = cfg_data;
					default: ;
				endcase
			end
			if (req_valid && !req_stall) begin
				if (req_data.mode == MODE_TICK) begin
					for (int i = 0; i < LINES && i < LEVEL_W; i++)
						take_sample(i, req_data.line_levels[i]);
				end else begin
					coil    = read_count(2 * req_data.pair_select, req_data.clear_previous);
					contact = read_count(2 * req_data.pair_select + 1,
						req_data.clear_previous);
					want.flash_result = {coil, contact};
					want.pair_echo    = req_data.pair_select;
					expected_counts.push_back(want);
				end
			end
			reads_waiting = expected_counts.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the flash counter testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps
module testbench;
	import sflc_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 12;
	localparam int PLAN_LEN      = 10;
	localparam int PLAN_ITEMS    = 75;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req_data;
	logic                 res_valid;
	logic                 res_stall;
	res_t                 res_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int mismatch_count;
	int reads_waiting;
	int reads_checked;
	int idle_cycles    = 0;
	int requests_sent  = 0;
	int settings_used  = 1;
	int stable_now     = 20;

	bit tx_gaps   = 1'b1;
	bit rx_gaps   = 1'b1;
	bit hold_ask  = 1'b0;
	bit hold_done = 1'b0;

	// Limit settings per random phase; the last one is drawn at run time
	int window_plan [PLAN_LEN] = '{1, 255, 5, 12, 3, 40, 8, 255, 1, 0};
	int stable_plan [PLAN_LEN] = '{1, 255, 2, 4, 7, 10, 3, 1, 255, 0};

	// Per-line waveform: current level and samples left in the current run
	logic [LEVEL_W-1:0] cur_levels;
	int                 run_left [LEVEL_W];

	safety_loop_flash_counter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	flash_count_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req_data       (req_data),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.res_data       (res_data),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.reads_waiting  (reads_waiting),
		.reads_checked  (reads_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: random stall bursts, one long hold-off on request
	initial begin
		res_stall = 1'b0;
		forever begin
			if (hold_ask && !hold_done) begin
				res_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else if (rx_gaps && $urandom_range(0, 2) == 0) begin
				res_stall = 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end else begin
				res_stall = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
		end
	end

	function automatic req_t make_request(logic mode, logic [LEVEL_W-1:0] levels,
		logic pair, logic clr);
		req_t r;
		r.mode           = mode;
		r.line_levels    = levels;
		r.pair_select    = pair;
		r.clear_previous = clr;
		return r;
	endfunction

	// Offer one request from a falling edge and hold it until taken
	task automatic send_request(req_t r);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		req_valid = 1'b1;
		req_data  = r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
		requests_sent++;
	endtask

	// Stop offering and wait for every outstanding read result
	task automatic drain();
		req_valid = 1'b0;
		@(negedge clk);
		while (reads_waiting != 0)
			@(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Let the block go idle, then load both limits
	task automatic program_limits(int wl, int sl);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_register(CFG_WINDOW_LIMIT, CFG_W'(wl));
		write_register(CFG_STABLE_LIMIT, CFG_W'(sl));
		stable_now = sl;
		settings_used++;
	endtask

	initial begin
		req_t r;
		int   wl;
		int   sl;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_data  = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		cur_levels = '0;
		for (int l = 0; l < LEVEL_W; l++)
			run_left[l] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty reads, all-equal and alternating levels, both pairs and clears
		send_request(make_request(MODE_READ, 4'h0, 1'b0, 1'b0));
		send_request(make_request(MODE_READ, 4'hF, 1'b1, 1'b1));
		send_request(make_request(MODE_TICK, 4'h0, 1'b0, 1'b0));
		send_request(make_request(MODE_TICK, 4'hF, 1'b1, 1'b1));
		send_request(make_request(MODE_TICK, 4'h5, 1'b0, 1'b1));
		send_request(make_request(MODE_TICK, 4'hA, 1'b1, 1'b0));
		send_request(make_request(MODE_TICK, 4'hF, 1'b0, 1'b0));
		send_request(make_request(MODE_TICK, 4'h0, 1'b0, 1'b0));
		send_request(make_request(MODE_TICK, 4'h3, 1'b0, 1'b0));
		send_request(make_request(MODE_TICK, 4'hC, 1'b0, 1'b0));
		send_request(make_request(MODE_READ, 4'hF, 1'b0, 1'b1));
		send_request(make_request(MODE_READ, 4'h0, 1'b1, 1'b0));
		send_request(make_request(MODE_READ, 4'h0, 1'b0, 1'b0));
		send_request(make_request(MODE_READ, 4'hF, 1'b1, 1'b1));

		// Random: mostly shaped line waveforms, some reads, some raw noise
		for (int p = 0; p < PLAN_LEN; p++) begin
			wl = window_plan[p];
			sl = stable_plan[p];
			if (p == PLAN_LEN - 1) begin
				wl      = $urandom_range(1, 255);
				sl      = $urandom_range(1, 12);
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end
			program_limits(wl, sl);
			for (int n = 0; n < PLAN_ITEMS; n++) begin
				// hold off results so the block backs up into the request port
				if (p == 2 && n == 20)
					hold_ask = 1'b1;
				if (p == 4 && n == 40)
					drain();
				if ((p == 2 && n >= 20 && n < 23) || $urandom_range(0, 5) == 0) begin
					r = make_request(MODE_READ, 4'($urandom), 1'($urandom), 1'($urandom));
				end else if ($urandom_range(0, 9) == 0) begin
					r = make_request(MODE_TICK, 4'($urandom), 1'($urandom), 1'($urandom));
				end else begin
					for (int l = 0; l < LEVEL_W; l++) begin
						if (run_left[l] == 0) begin
							cur_levels[l] = ~cur_levels[l];
							case ($urandom_range(0, 9))
								0, 1, 2, 3: run_left[l] = $urandom_range(1, 3);
								4, 5, 6, 7: run_left[l] = $urandom_range(1, stable_now + 2);
								default: run_left[l] = $urandom_range(stable_now,
									3 * stable_now + 3);
							endcase
						end
						run_left[l]--;
					end
					r = make_request(MODE_TICK, cur_levels, 1'($urandom), 1'($urandom));
				end
				send_request(r);
			end
		end

		drain();
		repeat (20) @(negedge clk);
		$display("Covered %0d requests and %0d checked read results over %0d limit settings,",
			requests_sent, reads_checked, settings_used);
		$display("with flash and steady-run waveforms, a result hold-off and a full drain.");
		if (mismatch_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
